[design/rnlp_pkg.sv]
// shared types and constants for the radix number literal parser
package rnlp_pkg;

	localparam logic [2:0] MODE_DEC  = 3'd0;
	localparam logic [2:0] MODE_OCT  = 3'd1;
	localparam logic [2:0] MODE_HEX  = 3'd2;
	localparam logic [2:0] MODE_BIN  = 3'd3;
	localparam logic [2:0] MODE_SDEC = 3'd4;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_UNDER = 8'h5f;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_char;
		logic       last_char;
		logic [2:0] radix_mode;
	} rnlp_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        invalid;
	} rnlp_res_t;

	// what one character means under its mode
	typedef struct packed {
		logic       digit_ok;
		logic [3:0] digit;
		logic       sign;
		logic       neg;
		logic       sep;
		logic       illegal;
	} rnlp_cls_t;

endpackage

[design/rnlp_classify.sv]
// character classifier: digit value, sign, separator and legality per radix
module rnlp_classify import rnlp_pkg::*; (
	input  logic [7:0] char_code,
	input  logic       first_char,
	input  logic [2:0] radix_mode,
	output rnlp_cls_t  cls
);

	logic       is_dig;
	logic [3:0] dval;
	logic [4:0] base;

	always_comb begin
		is_dig = 1'b1;
		dval   = 4'd0;
		if (char_code >= CH_0 && char_code <= CH_9) begin
			dval = 4'(char_code - CH_0);
		end else if (char_code >= CH_LA && char_code <= CH_LF) begin
			dval = 4'(char_code - CH_LA + 8'd10);
		end else if (char_code >= CH_UA && char_code <= CH_UF) begin
			dval = 4'(char_code - CH_UA + 8'd10);
		end else begin
			is_dig = 1'b0;
		end
	end

	always_comb begin
		unique case (radix_mode)
			MODE_DEC:  base = 5'd10;
			MODE_OCT:  base = 5'd8;
			MODE_HEX:  base = 5'd16;
			MODE_BIN:  base = 5'd2;
			MODE_SDEC: base = 5'd10;
			default:   base = 5'd0;
		endcase
	end

	always_comb begin
		cls.digit    = dval;
		cls.digit_ok = is_dig && ({1'b0, dval} < base);
		cls.sign     = (radix_mode == MODE_SDEC) && first_char
			&& (char_code == CH_MINUS || char_code == CH_PLUS);
		cls.neg      = (char_code == CH_MINUS);
		cls.sep      = (radix_mode == MODE_BIN) && (char_code == CH_UNDER);
		// unused modes have base zero, so nothing is a digit there either
		cls.illegal  = (base == 5'd0) || !(cls.sign || cls.sep || cls.digit_ok);
	end

endmodule

[design/rnlp_accum.sv]
// literal state: horner accumulator, error and sign flags, result formation
module rnlp_accum import rnlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       first_char,
	input  logic       last_char,
	input  logic [2:0] radix_mode,
	input  rnlp_cls_t  cls,
	output rnlp_res_t  result
);

	logic [31:0] acc_q;
	logic        err_q;
	logic        neg_q;

	logic [31:0] acc_cur;
	logic        err_cur;
	logic        neg_cur;
	logic [31:0] acc_scaled;
	logic [31:0] acc_nxt;
	logic        err_nxt;
	logic        neg_nxt;

	always_comb begin
		acc_cur = first_char ? 32'd0 : acc_q;
		err_cur = first_char ? 1'b0 : err_q;
		neg_cur = first_char ? 1'b0 : neg_q;

		// multiply by the radix as shift-adds
		unique case (radix_mode)
			MODE_OCT: acc_scaled = acc_cur << 3;
			MODE_HEX: acc_scaled = acc_cur << 4;
			MODE_BIN: acc_scaled = acc_cur << 1;
			default:  acc_scaled = (acc_cur << 3) + (acc_cur << 1);
		endcase

		acc_nxt = acc_cur;
		err_nxt = err_cur;
		neg_nxt = neg_cur;
		if (cls.illegal) begin
			err_nxt = 1'b1;
		end else if (cls.sign) begin
			neg_nxt = cls.neg;
		end else if (!cls.sep) begin
			acc_nxt = acc_scaled + {28'd0, cls.digit};
		end

		result.invalid = err_nxt;
		if (err_nxt) begin
			result.value = 32'd0;
		end else if (neg_nxt) begin
			result.value = 32'd0 - acc_nxt;
		end else begin
			result.value = acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
			err_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				acc_q <= 32'd0;
				err_q <= 1'b0;
				neg_q <= 1'b0;
			end else begin
				acc_q <= acc_nxt;
				err_q <= err_nxt;
				neg_q <= neg_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	a_clear_acc: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_char |=> acc_q == 32'd0)
		else $error("accumulator not cleared after last character");
	a_clear_flags: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_char |=> !err_q && !neg_q)
		else $error("flags not cleared after last character");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_char && cls.illegal |=> err_q)
		else $error("illegal character did not set error");
	a_minus: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_char && !cls.illegal && cls.sign && cls.neg |=> neg_q)
		else $error("leading minus not recorded");
`endif

endmodule

[design/radix_number_literal_parser.sv]
// top level: request register, classifier, accumulator and result register
//
//  channel | signals                     | carries
//  request | req_valid, req_stall, req   | one character with marks and radix mode
//  result  | res_valid, res_stall, res   | value and invalid flag, one per literal
//
// one character per cycle while the request side does not stall; the request register takes
// a character and the result register loads the result from it, so res_valid rises once the
// last character has passed through both registers. arst_n clears valid bits and literal state.
// the request side stalls only while a last character waits behind a stalled
// result; other characters keep flowing.
module radix_number_literal_parser import rnlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  rnlp_req_t req,
	output logic      res_valid,
	input  logic      res_stall,
	output rnlp_res_t res
);

	logic      valid_s1;
	rnlp_req_t req_s1;
	logic      res_valid_q;
	rnlp_res_t res_q;
	logic      step;
	rnlp_cls_t cls;
	rnlp_res_t result;

	// a last character cannot move while the result register is still held
	assign req_stall = valid_s1 && req_s1.last_char && res_valid_q && res_stall;
	assign step      = valid_s1 && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	rnlp_classify u_classify (
		.char_code  (req_s1.char_code),
		.first_char (req_s1.first_char),
		.radix_mode (req_s1.radix_mode),
		.cls        (cls)
	);

	rnlp_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.first_char (req_s1.first_char),
		.last_char  (req_s1.last_char),
		.radix_mode (req_s1.radix_mode),
		.cls        (cls),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && req_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && req_s1.last_char) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && req_s1.last_char && res_valid_q)
		else $error("request stalled without a blocked last character");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.invalid |-> res.value == 32'd0)
		else $error("invalid result carries a nonzero value");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		step && req_s1.last_char |=> res_valid)
		else $error("last character did not produce a result");
`endif

endmodule

[tb/sv/tb_top.sv]
// testbench for the radix number literal parser: directed and random literals, scoreboard check
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rnlp_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int STIM_CHARS = 650;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	// running literal value and expected results
	class literal_scoreboard;
		logic [31:0] acc;
		bit          err_seen;
		bit          negate;
		rnlp_res_t   pending[$];
		int          n_chars;
		int          n_literals;
		int          n_invalid;
		int          n_checked;
		int          n_errors;

		function new();
			clear_literal();
		endfunction

		function void clear_literal();
			acc = '0;
			err_seen = 1'b0;
			negate = 1'b0;
		endfunction

		// digit value of a character, 31 when it is no digit at all
		function logic [4:0] digit_of(logic [7:0] c);
			if (c >= CH_0 && c <= CH_9)
				return 5'(c - CH_0);
			if (c >= CH_LA && c <= CH_LF)
				return 5'(c - CH_LA) + 5'd10;
			if (c >= CH_UA && c <= CH_UF)
				return 5'(c - CH_UA) + 5'd10;
			return 5'd31;
		endfunction

		function void note_request(rnlp_req_t r);
			logic [4:0] base;
			logic [4:0] d;
			rnlp_res_t  out;
			n_chars++;
			if (r.first_char)
				clear_literal();
			case (r.radix_mode)
				MODE_DEC, MODE_SDEC: base = 5'd10;
				MODE_OCT: base = 5'd8;
				MODE_HEX: base = 5'd16;
				MODE_BIN: base = 5'd2;
				default: base = 5'd0;
			endcase
			d = digit_of(r.char_code);
			if (base == 5'd0) begin
				err_seen = 1'b1;
			end else if (r.radix_mode == MODE_SDEC && r.first_char &&
					(r.char_code == CH_MINUS || r.char_code == CH_PLUS)) begin
				negate = (r.char_code == CH_MINUS);
			end else if (r.radix_mode == MODE_BIN && r.char_code == CH_UNDER) begin
				// separator, skipped
			end else if (d >= base) begin
				err_seen = 1'b1;
			end else begin
				acc = acc * base + d;
			end
			if (r.last_char) begin
				out.value = err_seen ? 32'd0 : (negate ? 32'd0 - acc : acc);
				out.invalid = err_seen;
				pending.push_back(out);
				n_literals++;
				if (err_seen)
					n_invalid++;
				clear_literal();
			end
		endfunction

		task report(string what);
			if (n_errors < 100)
				$display("[%0t] mismatch: %s", $time, what);
			n_errors++;
		endtask

		task check_result(rnlp_res_t got);
			rnlp_res_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result value %h invalid %b", got.value, got.invalid));
				return;
			end
			want = pending.pop_front();
			if (got.value !== want.value)
				report($sformatf("value got %h want %h", got.value, want.value));
			if (got.invalid !== want.invalid)
				report($sformatf("invalid got %b want %b", got.invalid, want.invalid));
			n_checked++;
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	rnlp_req_t req = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	rnlp_res_t res;

	literal_scoreboard sb;
	int burst_left = 0;
	int stall_run = 0;

	radix_number_literal_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always #4 clk = ~clk;

	// one request per call, with burst gaps in front
	task automatic send_char(logic [7:0] c, logic first, logic last, logic [2:0] mode);
		int        gap;
		rnlp_req_t item;
		item.char_code = c;
		item.first_char = first;
		item.last_char = last;
		item.radix_mode = mode;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(item);
		burst_left--;
	endtask

	task automatic send_text(string s, logic [2:0] mode);
		for (int k = 0; k < s.len(); k++)
			send_char(s[k], k == 0, k == s.len() - 1, mode);
	endtask

	function automatic logic [7:0] legal_char(logic [2:0] mode, bit at_start);
		int unsigned k;
		case (mode)
			MODE_DEC: return CH_0 + 8'($urandom_range(0, 9));
			MODE_OCT: return CH_0 + 8'($urandom_range(0, 7));
			MODE_HEX: begin
				k = $urandom_range(0, 21);
				if (k < 10)
					return CH_0 + 8'(k);
				if (k < 16)
					return CH_LA + 8'(k - 10);
				return CH_UA + 8'(k - 16);
			end
			MODE_BIN: begin
				if ($urandom_range(0, 4) == 0)
					return CH_UNDER;
				return CH_0 + 8'($urandom_range(0, 1));
			end
			MODE_SDEC: begin
				if (at_start && $urandom_range(0, 2) == 0)
					return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
				return CH_0 + 8'($urandom_range(0, 9));
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly clean literals; a sloppy one gets stray bytes, modes and marks
	task automatic random_literal();
		int         len;
		bit         sloppy;
		logic [2:0] mode;
		logic [2:0] char_mode;
		logic [7:0] c;
		logic       first;
		logic       last;
		mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
			: 3'($urandom_range(MODE_DEC, MODE_SDEC));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		sloppy = ($urandom_range(0, 5) == 0);
		for (int k = 0; k < len; k++) begin
			c = legal_char(mode, k == 0);
			char_mode = mode;
			first = (k == 0);
			last = (k == len - 1);
			if (sloppy) begin
				if ($urandom_range(0, 3) == 0)
					c = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 5) == 0)
					char_mode = 3'($urandom_range(0, 7));
				if ($urandom_range(0, 7) == 0)
					first = ~first;
				if ($urandom_range(0, 7) == 0)
					last = ~last;
			end
			send_char(c, first, last, char_mode);
		end
	endtask

	// result side: check and stall pattern
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			sb.check_result(res);
		if (stall_run == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					res_stall <= 1'b0;
					stall_run = $urandom_range(20, 80);
				end
				1: begin
					res_stall <= 1'b1;
					stall_run = $urandom_range(1, 30);
				end
				default: begin
					res_stall <= 1'($urandom_range(0, 1));
					stall_run = $urandom_range(1, 3);
				end
			endcase
		end else begin
			stall_run--;
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_text("-9", MODE_SDEC);
		send_text("+", MODE_SDEC);
		send_text("-", MODE_SDEC);
		send_text("fF", MODE_HEX);
		send_text("1_0", MODE_BIN);
		send_text("7", MODE_OCT);
		send_text("8", MODE_OCT);
		send_char(8'h00, 1'b1, 1'b1, MODE_DEC);
		send_char(8'hff, 1'b1, 1'b1, MODE_DEC);
		send_char(CH_0 + 8'd1, 1'b1, 1'b1, MODE_SPARE_HI);
		send_char(CH_0 + 8'd1, 1'b1, 1'b1, MODE_SPARE_LO);
		// no first mark right after a finished literal
		send_char(CH_0 + 8'd5, 1'b0, 1'b1, MODE_DEC);
		// mode changes inside one literal
		send_char(CH_LA, 1'b1, 1'b0, MODE_HEX);
		send_char(CH_9, 1'b0, 1'b1, MODE_DEC);
		send_text("1+", MODE_SDEC);
		send_text("-", MODE_DEC);
		// a first mark mid-literal restarts it
		send_char(CH_0 + 8'd3, 1'b1, 1'b0, MODE_DEC);
		send_char(CH_0 + 8'd4, 1'b1, 1'b1, MODE_DEC);

		while (sb.n_chars < STIM_CHARS)
			random_literal();
		req_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d characters forming %0d literals, %0d of them invalid",
			sb.n_chars, sb.n_literals, sb.n_invalid);
		$display("checked %0d results, %0d mismatches", sb.n_checked, sb.n_errors);
		if (sb.n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
